// ----- sv/tpcu_pkg.sv -----
// ----------------------------------------------------------------------------
// Turtle pen command unit package
// Command codes, field widths, reset values and the types shared between the
// top level and the command step logic.
// ----------------------------------------------------------------------------
package tpcu_pkg;

  // Field widths of the transaction payloads
  localparam int MODE_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int COORD_W  = 9;
  localparam int COLOUR_W = 8;

  // Default canvas size
  localparam int CANVAS_WIDTH_DEF  = 512;
  localparam int CANVAS_HEIGHT_DEF = 512;

  // Brightest grey level
  localparam logic [COLOUR_W-1:0] COLOUR_MAX = '1;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PEN_DOWN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEN_UP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TURN_RIGHT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TURN_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COLOUR     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FORWARD    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BACKWARD   = 3'd6;

  typedef logic [1:0] heading_t;

  // Heading codes: bit 0 selects the y axis, bit 1 the negative direction
  localparam heading_t HEADING_POS_X = 2'd0;
  localparam heading_t HEADING_POS_Y = 2'd1;
  localparam heading_t HEADING_NEG_X = 2'd2;
  localparam heading_t HEADING_NEG_Y = 2'd3;

  // Pen state that is not a coordinate
  typedef struct packed {
    heading_t            heading;
    logic [COLOUR_W-1:0] colour;
    logic                down;
  } tpcu_pen_t;

  localparam tpcu_pen_t PEN_RESET = '{
    heading: HEADING_POS_X,
    colour:  '0,
    down:    1'b1
  };

  // One result transaction
  typedef struct packed {
    logic                line_draw;
    logic [COORD_W-1:0]  line_x0;
    logic [COORD_W-1:0]  line_y0;
    logic [COORD_W-1:0]  line_x1;
    logic [COORD_W-1:0]  line_y1;
    logic [COLOUR_W-1:0] line_colour;
    logic [COORD_W-1:0]  end_x;
    logic [COORD_W-1:0]  end_y;
  } tpcu_result_t;

endpackage

// ----- sv/tpcu_step.sv -----
// ----------------------------------------------------------------------------
// Turtle pen command step
// Applies one command to the turtle state: pen and heading updates, colour
// saturation, and the clamped move along the heading. Builds the result.
// ----------------------------------------------------------------------------
module tpcu_step
  import tpcu_pkg::*;
#(
  parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF,
  localparam int XW = $clog2(CANVAS_WIDTH),
  localparam int YW = $clog2(CANVAS_HEIGHT)
) (
  input  logic [MODE_W-1:0]          mode,
  input  logic signed [AMOUNT_W-1:0] amount,
  input  logic [XW-1:0]              cur_x,
  input  logic [YW-1:0]              cur_y,
  input  tpcu_pen_t                  pen,
  output logic [XW-1:0]              x_nxt,
  output logic [YW-1:0]              y_nxt,
  output tpcu_pen_t                  pen_nxt,
  output tpcu_result_t               result
);

  // Sum width: coordinate plus a negated step, with a sign bit
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int DW    = ((CW + 1) > (AMOUNT_W + 1)) ? (CW + 1) : (AMOUNT_W + 1);
  localparam int SUM_W = DW + 1;

  localparam logic signed [SUM_W-1:0] X_LIMIT = SUM_W'(CANVAS_WIDTH - 1);
  localparam logic signed [SUM_W-1:0] Y_LIMIT = SUM_W'(CANVAS_HEIGHT - 1);

  localparam logic signed [AMOUNT_W-1:0] AMOUNT_COLOUR_MAX = AMOUNT_W'(COLOUR_MAX);

  logic                    is_move;
  logic                    flip;
  logic signed [SUM_W-1:0] amt_ext;
  logic signed [SUM_W-1:0] delta;
  logic signed [SUM_W-1:0] base_x;
  logic signed [SUM_W-1:0] base_y;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [XW-1:0]           move_x;
  logic [YW-1:0]           move_y;
  logic [COLOUR_W-1:0]     colour_sat;

  // Signed step along the heading; backward and negative headings flip it
  always_comb begin
    is_move = (mode == MODE_FORWARD) || (mode == MODE_BACKWARD);
    flip    = (mode == MODE_BACKWARD) ^ pen.heading[1];
    amt_ext = SUM_W'(amount);
    delta   = flip ? -amt_ext : amt_ext;
    base_x  = $signed(SUM_W'(cur_x));
    base_y  = $signed(SUM_W'(cur_y));
    sum_x   = pen.heading[0] ? base_x : base_x + delta;
    sum_y   = pen.heading[0] ? base_y + delta : base_y;
  end

  // Clamp each coordinate to the canvas
  always_comb begin
    if (sum_x < 0) begin
      move_x = '0;
    end else if (sum_x > X_LIMIT) begin
      move_x = X_LIMIT[XW-1:0];
    end else begin
      move_x = sum_x[XW-1:0];
    end
    if (sum_y < 0) begin
      move_y = '0;
    end else if (sum_y > Y_LIMIT) begin
      move_y = Y_LIMIT[YW-1:0];
    end else begin
      move_y = sum_y[YW-1:0];
    end
  end

  // Saturate the colour value to a grey level
  always_comb begin
    if (amount < 0) begin
      colour_sat = '0;
    end else if (amount > AMOUNT_COLOUR_MAX) begin
      colour_sat = COLOUR_MAX;
    end else begin
      colour_sat = amount[COLOUR_W-1:0];
    end
  end

  // Decode the command
  always_comb begin
    pen_nxt = pen;
    x_nxt   = cur_x;
    y_nxt   = cur_y;
    unique case (mode)
      MODE_PEN_DOWN:   pen_nxt.down    = 1'b1;
      MODE_PEN_UP:     pen_nxt.down    = 1'b0;
      MODE_TURN_RIGHT: pen_nxt.heading = pen.heading + 2'd1;
      MODE_TURN_LEFT:  pen_nxt.heading = pen.heading - 2'd1;
      MODE_COLOUR:     pen_nxt.colour  = colour_sat;
      MODE_FORWARD, MODE_BACKWARD: begin
        x_nxt = move_x;
        y_nxt = move_y;
      end
      default: begin
        // unused code: hold the state
      end
    endcase
  end

  // Build the result transaction
  always_comb begin
    result.line_draw   = is_move & pen.down;
    result.line_x0     = COORD_W'(cur_x);
    result.line_y0     = COORD_W'(cur_y);
    result.line_x1     = COORD_W'(x_nxt);
    result.line_y1     = COORD_W'(y_nxt);
    result.line_colour = pen_nxt.colour;
    result.end_x       = COORD_W'(x_nxt);
    result.end_y       = COORD_W'(y_nxt);
  end

endmodule

// ----- sv/turtle_pen_command_unit.sv -----
// ----------------------------------------------------------------------------
// Turtle pen command unit
// Interprets pen-plotter commands and reports one segment result per command.
// ----------------------------------------------------------------------------
// The unit accepts one command every clock cycle while the output is not
// stalled and returns one result for each, in order. A command is held in an
// input register, applied to the turtle state by combinational add, clamp and
// select logic, and placed in the result register, whose loading raises
// out_valid. The state update of one command feeds the next through the
// turtle state registers, which sets the rate of one command per cycle
// while the output is not stalled. While a result waits on out_ready the
// input register still takes one more command, and in_ready falls only
// when both are full.
// ----------------------------------------------------------------------------
module turtle_pen_command_unit
  import tpcu_pkg::*;
#(
  parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [AMOUNT_W-1:0] in_amount,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_line_draw,
  output logic [COORD_W-1:0]         out_line_x0,
  output logic [COORD_W-1:0]         out_line_y0,
  output logic [COORD_W-1:0]         out_line_x1,
  output logic [COORD_W-1:0]         out_line_y1,
  output logic [COLOUR_W-1:0]        out_line_colour,
  output logic [COORD_W-1:0]         out_end_x,
  output logic [COORD_W-1:0]         out_end_y
);

  localparam int XW = $clog2(CANVAS_WIDTH);
  localparam int YW = $clog2(CANVAS_HEIGHT);

  localparam logic [XW-1:0] X_MAX = XW'(CANVAS_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(CANVAS_HEIGHT - 1);

  // Input register
  logic                       in_vld_r;
  logic [MODE_W-1:0]          mode_r;
  logic signed [AMOUNT_W-1:0] amount_r;

  // Turtle state
  logic [XW-1:0] cur_x_r;
  logic [YW-1:0] cur_y_r;
  tpcu_pen_t     pen_r;
  logic [XW-1:0] cur_x_nxt;
  logic [YW-1:0] cur_y_nxt;
  tpcu_pen_t     pen_nxt;

  // Result register
  logic         out_vld_r;
  tpcu_result_t res_r;
  tpcu_result_t res_nxt;

  logic advance;

  // Move a command out of the input register when the result slot frees up
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  tpcu_step #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_step (
    .mode    (mode_r),
    .amount  (amount_r),
    .cur_x   (cur_x_r),
    .cur_y   (cur_y_r),
    .pen     (pen_r),
    .x_nxt   (cur_x_nxt),
    .y_nxt   (cur_y_nxt),
    .pen_nxt (pen_nxt),
    .result  (res_nxt)
  );

  // Capture an accepted command transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      amount_r <= in_amount;
    end
  end

  // Advance the turtle state once per applied command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      pen_r   <= PEN_RESET;
    end else if (advance) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      pen_r   <= pen_nxt;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_line_draw   = res_r.line_draw;
  assign out_line_x0     = res_r.line_x0;
  assign out_line_y0     = res_r.line_y0;
  assign out_line_x1     = res_r.line_x1;
  assign out_line_y1     = res_r.line_y1;
  assign out_line_colour = res_r.line_colour;
  assign out_end_x       = res_r.end_x;
  assign out_end_y       = res_r.end_y;

`ifndef ASSERT_OFF
  // The turtle never leaves the canvas
  a_on_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_x_r <= X_MAX) && (cur_y_r <= Y_MAX))
    else $error("turtle position off the canvas");

  // An empty result slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with an empty result register");

  // A command other than a move reports a point and draws nothing
  a_still_point: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (mode_r != MODE_FORWARD) && (mode_r != MODE_BACKWARD) |=>
      !res_r.line_draw && (res_r.line_x0 == res_r.line_x1) &&
      (res_r.line_y0 == res_r.line_y1))
    else $error("non-move command produced a segment");

  // A right turn steps the heading by one
  a_turn_right: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (mode_r == MODE_TURN_RIGHT) |=>
      pen_r.heading == 2'($past(pen_r.heading) + 2'd1))
    else $error("right turn did not advance the heading");
`endif

endmodule

// ----- sim/turtle_pen_command_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Turtle pen command unit testbench
// Sends pen, turn, colour and move commands through the valid/ready input,
// tracks the turtle position, heading, colour and pen flag alongside the
// block, and checks every result transaction field by field, in order.
// Both sides idle in random bursts, and the receiver holds off once for long
// enough that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module turtle_pen_command_unit_tb;
  import tpcu_pkg::*;

  localparam int CANVAS_W     = CANVAS_WIDTH_DEF;
  localparam int CANVAS_H     = CANVAS_HEIGHT_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int TAIL_ITEMS   = 80;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 64;
  localparam int SETTLE       = 8;
  localparam int TIMEOUT      = 2_000_000;

  // Code outside the defined commands; the block must treat it as a no-op
  localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [AMOUNT_W-1:0] amount;
    bit                         drain;
  } pen_cmd_t;

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [MODE_W-1:0]          in_mode   = '0;
  logic signed [AMOUNT_W-1:0] in_amount = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_line_draw;
  logic [COORD_W-1:0]         out_line_x0;
  logic [COORD_W-1:0]         out_line_y0;
  logic [COORD_W-1:0]         out_line_x1;
  logic [COORD_W-1:0]         out_line_y1;
  logic [COLOUR_W-1:0]        out_line_colour;
  logic [COORD_W-1:0]         out_end_x;
  logic [COORD_W-1:0]         out_end_y;

  pen_cmd_t     pending_cmds[$];
  tpcu_result_t segments_due[$];

  // Turtle state as the block should hold it
  int                  pos_x       = 0;
  int                  pos_y       = 0;
  heading_t            pen_heading = PEN_RESET.heading;
  logic [COLOUR_W-1:0] pen_colour  = PEN_RESET.colour;
  logic                pen_is_down = PEN_RESET.down;

  int  total_items    = 0;
  int  items_accepted = 0;
  int  results_seen   = 0;
  int  segments_drawn = 0;
  int  moves_clamped  = 0;
  int  colours_sat    = 0;
  int  mismatches     = 0;
  bit  in_took        = 1'b0;
  bit  hold_off       = 1'b0;
  int  send_gap       = 0;
  int  send_quiet     = 0;
  int  recv_gap       = 0;
  int  recv_quiet     = 0;

  turtle_pen_command_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_draw   (out_line_draw),
    .out_line_x0     (out_line_x0),
    .out_line_y0     (out_line_y0),
    .out_line_x1     (out_line_x1),
    .out_line_y1     (out_line_y1),
    .out_line_colour (out_line_colour),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y)
  );

  // Generate the clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one command to the turtle state and build the segment it reports
  function automatic tpcu_result_t predict_segment(logic [MODE_W-1:0] mode,
                                                   logic signed [AMOUNT_W-1:0] amount);
    tpcu_result_t seg;
    int           step;
    int           nx;
    int           ny;
    seg.line_x0   = pos_x[COORD_W-1:0];
    seg.line_y0   = pos_y[COORD_W-1:0];
    seg.line_draw = 1'b0;
    case (mode)
      MODE_PEN_DOWN:   pen_is_down = 1'b1;
      MODE_PEN_UP:     pen_is_down = 1'b0;
      MODE_TURN_RIGHT: pen_heading = pen_heading + 2'd1;
      MODE_TURN_LEFT:  pen_heading = pen_heading - 2'd1;
      MODE_COLOUR: begin
        if (int'(amount) < 0 || int'(amount) > int'(COLOUR_MAX)) colours_sat++;
        pen_colour = COLOUR_W'(clamp_to(int'(amount), int'(COLOUR_MAX)));
      end
      MODE_FORWARD, MODE_BACKWARD: begin
        step = (mode == MODE_BACKWARD) ? -int'(amount) : int'(amount);
        nx   = pos_x;
        ny   = pos_y;
        case (pen_heading)
          HEADING_POS_X: nx += step;
          HEADING_POS_Y: ny += step;
          HEADING_NEG_X: nx -= step;
          default:       ny -= step;
        endcase
        if (nx < 0 || nx > CANVAS_W - 1 || ny < 0 || ny > CANVAS_H - 1) moves_clamped++;
        pos_x         = clamp_to(nx, CANVAS_W - 1);
        pos_y         = clamp_to(ny, CANVAS_H - 1);
        seg.line_draw = pen_is_down;
      end
      default: ;
    endcase
    seg.line_x1     = pos_x[COORD_W-1:0];
    seg.line_y1     = pos_y[COORD_W-1:0];
    seg.line_colour = pen_colour;
    seg.end_x       = pos_x[COORD_W-1:0];
    seg.end_y       = pos_y[COORD_W-1:0];
    return seg;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic queue_cmd(input logic [MODE_W-1:0] mode,
                           input logic signed [AMOUNT_W-1:0] amount,
                           input bit drain = 1'b0);
    pen_cmd_t cmd;
    cmd.mode   = mode;
    cmd.amount = amount;
    cmd.drain  = drain;
    pending_cmds.push_back(cmd);
  endtask

  // Drive commands; hold each transaction until accepted
  always @(negedge clk) begin : driver
    pen_cmd_t next_cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_cmds[0].drain && segments_due.size() != 0) begin
      // pause until every outstanding result is back
      in_valid <= 1'b0;
    end else if (pending_cmds.size() >= TAIL_ITEMS && send_quiet == 0 &&
                 $urandom_range(0, 7) == 0) begin
      send_gap   <= $urandom_range(0, 9);
      send_quiet <= $urandom_range(0, 40);
      in_valid   <= 1'b0;
    end else begin
      next_cmd = pending_cmds.pop_front();
      if (send_quiet != 0) send_quiet <= send_quiet - 1;
      in_mode   <= next_cmd.mode;
      in_amount <= next_cmd.amount;
      in_valid  <= 1'b1;
    end
  end

  // Drive out_ready with random stall bursts
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (pending_cmds.size() < TAIL_ITEMS) begin
      out_ready <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (recv_quiet == 0 && $urandom_range(0, 7) == 0) begin
      recv_gap   <= $urandom_range(0, 9);
      recv_quiet <= $urandom_range(0, 40);
      out_ready  <= 1'b0;
    end else begin
      if (recv_quiet != 0) recv_quiet <= recv_quiet - 1;
      out_ready <= 1'b1;
    end
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin : monitor
    tpcu_result_t got;
    tpcu_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        segments_due.push_back(predict_segment(in_mode, in_amount));
        items_accepted <= items_accepted + 1;
      end
      if (out_valid && out_ready) begin
        got = '{out_line_draw, out_line_x0, out_line_y0, out_line_x1, out_line_y1,
                out_line_colour, out_end_x, out_end_y};
        results_seen <= results_seen + 1;
        if (segments_due.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          want = segments_due.pop_front();
          if (want.line_draw) segments_drawn <= segments_drawn + 1;
          check_field("line_draw",   got.line_draw,   want.line_draw);
          check_field("line_x0",     got.line_x0,     want.line_x0);
          check_field("line_y0",     got.line_y0,     want.line_y0);
          check_field("line_x1",     got.line_x1,     want.line_x1);
          check_field("line_y1",     got.line_y1,     want.line_y1);
          check_field("line_colour", got.line_colour, want.line_colour);
          check_field("end_x",       got.end_x,       want.end_x);
          check_field("end_y",       got.end_y,       want.end_y);
        end
      end
    end
  end

  // Hold off the receiver once so the block backs up and stalls its input
  initial begin : long_stall
    do @(negedge clk); while (items_accepted < HOLD_AFTER);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("** turtle_pen_command_unit: FAILED **");
    $finish;
  end

  // Build the stimulus, release reset, wait for the run to drain
  initial begin : stimulus
    int                sel;
    int                pick;
    int                amt;
    logic [MODE_W-1:0] mode;

    // Directed: extremes, every command, clamping on all four headings
    queue_cmd(MODE_FORWARD,    16'sd0);
    queue_cmd(MODE_FORWARD,    16'sd100);
    queue_cmd(MODE_COLOUR,     16'sd300);
    queue_cmd(MODE_TURN_RIGHT, 16'sh7fff);
    queue_cmd(MODE_FORWARD,    16'sh7fff);
    queue_cmd(MODE_COLOUR,     -16'sd1);
    queue_cmd(MODE_TURN_RIGHT, 16'sd0);
    queue_cmd(MODE_FORWARD,    16'sh8000);
    queue_cmd(MODE_BACKWARD,   16'sh8000);
    queue_cmd(MODE_PEN_UP,     16'shffff);
    queue_cmd(MODE_TURN_LEFT,  16'sh8000);
    queue_cmd(MODE_BACKWARD,   16'sd20);
    queue_cmd(MODE_FORWARD,    16'sd0);
    queue_cmd(MODE_TURN_LEFT,  16'sd0);
    queue_cmd(MODE_COLOUR,     16'sd255);
    queue_cmd(MODE_RESERVED,   16'sh8000);
    queue_cmd(MODE_PEN_DOWN,   16'sd12345);
    queue_cmd(MODE_BACKWARD,   16'sd1);
    queue_cmd(MODE_TURN_LEFT,  16'sd0);
    queue_cmd(MODE_FORWARD,    16'sd600);
    queue_cmd(MODE_COLOUR,     16'sd0);
    queue_cmd(MODE_COLOUR,     16'sd128);
    queue_cmd(MODE_TURN_RIGHT, 16'sd0);
    queue_cmd(MODE_FORWARD,    16'sd511);
    queue_cmd(MODE_BACKWARD,   -16'sd1);
    queue_cmd(MODE_RESERVED,   16'shffff);

    // Random: moves for nearly half the commands, mostly short steps, some full-range amounts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (pick < 7)      amt = int'($urandom_range(0, 600)) - 300;
      else if (pick < 9) amt = int'($urandom_range(0, 2000)) - 1000;
      else               amt = int'($urandom_range(0, 65535)) - 32768;
      if (sel < 25)      mode = MODE_FORWARD;
      else if (sel < 45) mode = MODE_BACKWARD;
      else if (sel < 53) mode = MODE_TURN_RIGHT;
      else if (sel < 61) mode = MODE_TURN_LEFT;
      else if (sel < 71) begin
        mode = MODE_COLOUR;
        if (pick < 7) amt = $urandom_range(0, 255);
      end
      else if (sel < 86) mode = MODE_PEN_DOWN;
      else if (sel < 97) mode = MODE_PEN_UP;
      else               mode = MODE_RESERVED;
      queue_cmd(mode, amt[AMOUNT_W-1:0], i == 0 || i == 300 || i == 550);
    end
    total_items = pending_cmds.size();

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (items_accepted != total_items);
    do @(negedge clk); while (segments_due.size() != 0);
    repeat (SETTLE) @(negedge clk);

    $display("Ran %0d commands, checked %0d results: %0d drawn segments,",
             total_items, results_seen, segments_drawn);
    $display("%0d moves clamped at the canvas edge, %0d colours saturated",
             moves_clamped, colours_sat);
    if (mismatches == 0 && segments_due.size() == 0) begin
      $display("** turtle_pen_command_unit: PASSED **");
    end else begin
      $display("** turtle_pen_command_unit: FAILED **");
    end
    $finish;
  end

endmodule
